@@ rtl/core/m3m_pkg.sv @@
package m3m_pkg;

   // sample width used inside the filter
   localparam int SAMPLE_BITS = 12;
   // width of the sample and average fields on the channels
   localparam int FIELD_BITS  = 12;
   // width of the group count register and the median counter
   localparam int COUNT_BITS  = 8;
   // running sum of up to 255 medians
   localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
   // bit counters of the serial units
   localparam int SCNT_BITS   = $clog2(SAMPLE_BITS);
   localparam int SUMCNT_BITS = $clog2(SUM_BITS);

   // position of a sample within its triple
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEDIAN,
      ST_ADD,
      ST_DIVIDE,
      ST_PUSH
   } state_type;

   // start and clear for the serial accumulator
   typedef struct packed {
      logic start;
      logic clear;
   } acc_ctrl_type;

endpackage

@@ rtl/core/m3m_if.sv @@
interface m3m_req_if;
   logic                              valid;
   logic                              ready;
   logic [m3m_pkg::FIELD_BITS-1:0]    sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface m3m_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [m3m_pkg::FIELD_BITS-1:0]    average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

@@ rtl/core/m3m_median.sv @@
module m3m_median (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [m3m_pkg::SAMPLE_BITS-1:0]  first,
   input  logic [m3m_pkg::SAMPLE_BITS-1:0]  second,
   input  logic [m3m_pkg::SAMPLE_BITS-1:0]  third,
   output logic                             done,
   output logic [m3m_pkg::SAMPLE_BITS-1:0]  median
);

   logic                             busy_ff, busy_in;
   logic                             pick_ff, pick_in;
   logic [m3m_pkg::SCNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [m3m_pkg::SAMPLE_BITS-1:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic                             ab_gt_ff, ab_gt_in;
   logic                             bc_gt_ff, bc_gt_in;
   logic                             ac_gt_ff, ac_gt_in;

   // lsb-first compare: a higher bit that differs overrides what lower bits said
   always_comb begin
      busy_in  = busy_ff;
      pick_in  = 1'b0;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      ab_gt_in = ab_gt_ff;
      bc_gt_in = bc_gt_ff;
      ac_gt_in = ac_gt_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         a_in     = first;
         b_in     = second;
         c_in     = third;
         ab_gt_in = 1'b0;
         bc_gt_in = 1'b0;
         ac_gt_in = 1'b0;
      end else if (busy_ff) begin
         a_in     = {a_ff[0], a_ff[m3m_pkg::SAMPLE_BITS-1:1]};
         b_in     = {b_ff[0], b_ff[m3m_pkg::SAMPLE_BITS-1:1]};
         c_in     = {c_ff[0], c_ff[m3m_pkg::SAMPLE_BITS-1:1]};
         ab_gt_in = (a_ff[0] & ~b_ff[0]) | (ab_gt_ff & ~(a_ff[0] ^ b_ff[0]));
         bc_gt_in = (b_ff[0] & ~c_ff[0]) | (bc_gt_ff & ~(b_ff[0] ^ c_ff[0]));
         ac_gt_in = (a_ff[0] & ~c_ff[0]) | (ac_gt_ff & ~(a_ff[0] ^ c_ff[0]));
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == m3m_pkg::SCNT_BITS'(m3m_pkg::SAMPLE_BITS - 1)) begin
            busy_in = 1'b0;
            pick_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pick_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pick_ff <= pick_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      ab_gt_ff <= ab_gt_in;
      bc_gt_ff <= bc_gt_in;
      ac_gt_ff <= ac_gt_in;
   end

   // words are back in place after a full rotation
   always_comb begin
      if (ab_gt_ff == bc_gt_ff) begin
         median = b_ff;
      end else if (ab_gt_ff) begin
         median = ac_gt_ff ? c_ff : a_ff;
      end else begin
         median = ac_gt_ff ? a_ff : c_ff;
      end
   end

   assign done = pick_ff;

endmodule

@@ rtl/core/m3m_accum.sv @@
module m3m_accum (
   input  logic                             clock,
   input  logic                             reset,
   input  m3m_pkg::acc_ctrl_type            ctrl,
   input  logic [m3m_pkg::SAMPLE_BITS-1:0]  addend,
   output logic                             done,
   output logic [m3m_pkg::SUM_BITS-1:0]     sum
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [m3m_pkg::SUMCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [m3m_pkg::SUM_BITS-1:0]     sum_ff, sum_in;
   logic [m3m_pkg::SAMPLE_BITS-1:0]  addend_ff, addend_in;
   logic                             carry_ff, carry_in;
   logic                             bit_sum;

   // sum rotates through a one-bit full adder, carry out of the top is dropped
   assign bit_sum = sum_ff[0] ^ addend_ff[0] ^ carry_ff;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      addend_in = addend_ff;
      carry_in  = carry_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end
      if (ctrl.start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         addend_in = addend;
         carry_in  = 1'b0;
      end else if (busy_ff) begin
         sum_in    = {bit_sum, sum_ff[m3m_pkg::SUM_BITS-1:1]};
         addend_in = addend_ff >> 1;
         carry_in  = (sum_ff[0] & addend_ff[0]) | (carry_ff & (sum_ff[0] ^ addend_ff[0]));
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == m3m_pkg::SUMCNT_BITS'(m3m_pkg::SUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         sum_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      addend_ff <= addend_in;
      carry_ff  <= carry_in;
   end

   assign done = done_ff;
   assign sum  = sum_ff;

endmodule

@@ rtl/core/m3m_divider.sv @@
module m3m_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [m3m_pkg::SUM_BITS-1:0]     dividend,
   input  logic [m3m_pkg::COUNT_BITS-1:0]   divisor,
   output logic                             done,
   output logic [m3m_pkg::SUM_BITS-1:0]     quotient
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [m3m_pkg::SUMCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [m3m_pkg::COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [m3m_pkg::COUNT_BITS-1:0]   den_ff, den_in;
   logic [m3m_pkg::SUM_BITS-1:0]     quo_ff, quo_in;
   logic [m3m_pkg::COUNT_BITS:0]     shifted;
   logic [m3m_pkg::COUNT_BITS+1:0]   diff;

   // restoring division, one quotient bit per cycle, msb first
   assign shifted = {rem_ff, quo_ff[m3m_pkg::SUM_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (!diff[m3m_pkg::COUNT_BITS+1]) begin
            rem_in = diff[m3m_pkg::COUNT_BITS-1:0];
            quo_in = {quo_ff[m3m_pkg::SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[m3m_pkg::COUNT_BITS-1:0];
            quo_in = {quo_ff[m3m_pkg::SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == m3m_pkg::SUMCNT_BITS'(m3m_pkg::SUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/median3_then_mean_filter.sv @@
// channel  | direction | word                 | handshake
// req_chan | in        | sample, 12 bits      | valid / ready
// rsp_chan | out       | average, 12 bits     | valid / ready
// csr_*    | in        | group_count, 8 bits  | write enable, no read-back
//
// first and second sample of a triple are held in registers
// third sample: goes through the bit-serial three-way compare and then the bit-serial
//   adder into the running sum
// a triple that closes a group then also runs the serial divider
// synchronous active-high reset clears state, group_count returns to 1
// a waiting average does not block input; only a second average stalls behind it
module median3_then_mean_filter (
   input  logic                            clock,
   input  logic                            reset,
   m3m_req_if.sink                         req_chan,
   m3m_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [m3m_pkg::COUNT_BITS-1:0]  csr_wr_data
);

   m3m_pkg::state_type                state_ff, state_in;
   logic [m3m_pkg::COUNT_BITS-1:0]    group_count_ff;
   logic [m3m_pkg::SAMPLE_BITS-1:0]   held_first_ff, held_first_in;
   logic [m3m_pkg::SAMPLE_BITS-1:0]   held_second_ff, held_second_in;
   logic [1:0]                        phase_ff, phase_in;
   logic [m3m_pkg::COUNT_BITS-1:0]    taken_ff, taken_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [m3m_pkg::FIELD_BITS-1:0]    rsp_average_ff, rsp_average_in;

   logic                              accept;
   logic [m3m_pkg::SAMPLE_BITS-1:0]   sample_w;
   logic                              med_start, med_done;
   logic [m3m_pkg::SAMPLE_BITS-1:0]   med_value;
   m3m_pkg::acc_ctrl_type             acc_ctrl;
   logic                              acc_done;
   logic [m3m_pkg::SUM_BITS-1:0]      acc_sum;
   logic                              div_start, div_done;
   logic [m3m_pkg::SUM_BITS-1:0]      div_quotient;
   logic [m3m_pkg::COUNT_BITS-1:0]    taken_next, limit;
   logic                              close_group;

   // input takes a word only when the serial units are free
   assign req_chan.ready = (state_ff == m3m_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign sample_w       = m3m_pkg::SAMPLE_BITS'(req_chan.sample);

   // a stored count of zero acts as one
   assign limit       = (group_count_ff == '0) ? m3m_pkg::COUNT_BITS'(1) : group_count_ff;
   assign taken_next  = taken_ff + 1'b1;
   // lowering the count mid-group closes the group on the next median
   assign close_group = (taken_next != '0) && (taken_next >= limit);

   m3m_median u_median (
      .clock  (clock),
      .reset  (reset),
      .start  (med_start),
      .first  (held_first_ff),
      .second (held_second_ff),
      .third  (sample_w),
      .done   (med_done),
      .median (med_value)
   );

   m3m_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (acc_ctrl),
      .addend (med_value),
      .done   (acc_done),
      .sum    (acc_sum)
   );

   // divisor is the number of medians actually summed
   m3m_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_sum),
      .divisor  (taken_next),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in       = state_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      phase_in       = phase_ff;
      taken_in       = taken_ff;
      rsp_average_in = rsp_average_ff;
      rsp_valid_in   = rsp_valid_ff;
      med_start      = 1'b0;
      acc_ctrl.start = 1'b0;
      acc_ctrl.clear = 1'b0;
      div_start      = 1'b0;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         m3m_pkg::ST_IDLE: begin
            if (accept) begin
               case (phase_ff)
                  m3m_pkg::PHASE_SECOND: begin
                     held_second_in = sample_w;
                     phase_in       = m3m_pkg::PHASE_THIRD;
                  end
                  m3m_pkg::PHASE_THIRD: begin
                     med_start = 1'b1;
                     phase_in  = m3m_pkg::PHASE_FIRST;
                     state_in  = m3m_pkg::ST_MEDIAN;
                  end
                  default: begin
                     held_first_in = sample_w;
                     phase_in      = m3m_pkg::PHASE_SECOND;
                  end
               endcase
            end
         end
         m3m_pkg::ST_MEDIAN: begin
            if (med_done) begin
               acc_ctrl.start = 1'b1;
               state_in       = m3m_pkg::ST_ADD;
            end
         end
         m3m_pkg::ST_ADD: begin
            if (acc_done) begin
               if (close_group) begin
                  div_start      = 1'b1;
                  acc_ctrl.clear = 1'b1;
                  taken_in       = '0;
                  state_in       = m3m_pkg::ST_DIVIDE;
               end else begin
                  taken_in = taken_next;
                  state_in = m3m_pkg::ST_IDLE;
               end
            end
         end
         m3m_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = m3m_pkg::ST_PUSH;
            end
         end
         m3m_pkg::ST_PUSH: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_average_in = m3m_pkg::FIELD_BITS'(div_quotient);
               rsp_valid_in   = 1'b1;
               state_in       = m3m_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = m3m_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= m3m_pkg::ST_IDLE;
         group_count_ff <= m3m_pkg::COUNT_BITS'(1);
         held_first_ff  <= '0;
         held_second_ff <= '0;
         phase_ff       <= m3m_pkg::PHASE_FIRST;
         taken_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
         phase_ff       <= phase_in;
         taken_ff       <= taken_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            group_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_average_ff <= rsp_average_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.average = rsp_average_ff;

   // each serial unit finishes only while the sequencer waits for it
   a_med_done_in_median: assert property (@(posedge clock) disable iff (reset)
      med_done |-> (state_ff == m3m_pkg::ST_MEDIAN))
      else $error("median finished outside its wait state");

   a_acc_done_in_add: assert property (@(posedge clock) disable iff (reset)
      acc_done |-> (state_ff == m3m_pkg::ST_ADD))
      else $error("accumulator finished outside its wait state");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == m3m_pkg::ST_DIVIDE))
      else $error("divider finished outside its wait state");

   // a group closes before the median counter can wrap
   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      taken_ff != {m3m_pkg::COUNT_BITS{1'b1}})
      else $error("median counter reached its top value");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("triple phase out of range");

endmodule

@@ tb/sv/tb_median3_then_mean_filter.sv @@
`timescale 1ns / 1ps

module tb_median3_then_mean_filter;

   // idle limit is far above the longest correct quiet stretch
   // (receiver hold-off plus settle plus one slow triple)
   localparam int IDLE_LIMIT    = 4000;
   // covers the serial median, the adder and the divider of one triple
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam logic [m3m_pkg::FIELD_BITS-1:0] SAMPLE_MASK =
      m3m_pkg::FIELD_BITS'((1 << m3m_pkg::SAMPLE_BITS) - 1);
   localparam logic [m3m_pkg::FIELD_BITS-1:0] FULL_SCALE  = '1;

   // receiver ready patterns
   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PERIODIC
   } rx_mode_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [m3m_pkg::COUNT_BITS-1:0] csr_wr_data;

   m3m_req_if req_chan ();
   m3m_rsp_if rsp_chan ();

   median3_then_mean_filter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the filter state, advanced on every accepted sample word
   logic [m3m_pkg::FIELD_BITS-1:0] first_sample     = '0;
   logic [m3m_pkg::FIELD_BITS-1:0] second_sample    = '0;
   logic [1:0]                     triple_pos       = m3m_pkg::PHASE_FIRST;
   logic [m3m_pkg::SUM_BITS-1:0]   running_sum      = '0;
   logic [m3m_pkg::COUNT_BITS-1:0] medians_in_group = '0;
   logic [m3m_pkg::COUNT_BITS-1:0] group_limit;

   // averages still owed by the block, oldest first
   logic [m3m_pkg::FIELD_BITS-1:0] expected_averages[$];

   int          error_count = 0;
   int          idle_cycles = 0;
   int          burst_left;
   bit          sender_gaps;
   rx_mode_type rx_mode;
   int          rx_tick     = 0;
   int          hold_request;
   int          hold_seen   = 0;
   int          hold_left   = 0;
   logic [m3m_pkg::FIELD_BITS-1:0] prev_sample;

   // free-running clock, 2 ns period
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [m3m_pkg::FIELD_BITS-1:0] median_of(
      input logic [m3m_pkg::FIELD_BITS-1:0] a,
      input logic [m3m_pkg::FIELD_BITS-1:0] b,
      input logic [m3m_pkg::FIELD_BITS-1:0] c);
      logic [m3m_pkg::FIELD_BITS-1:0] lo;
      logic [m3m_pkg::FIELD_BITS-1:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      // clamp the third sample between the smaller and larger of the first two
      if (c < lo) return lo;
      if (c > hi) return hi;
      return c;
   endfunction

   // one accepted sample: fill the triple, on its third sample fold the median
   // into the group and queue the truncated mean when the group closes
   function void track_sample(input logic [m3m_pkg::FIELD_BITS-1:0] raw);
      logic [m3m_pkg::FIELD_BITS-1:0] s;
      logic [m3m_pkg::FIELD_BITS-1:0] med;
      logic [m3m_pkg::COUNT_BITS-1:0] limit;
      logic [m3m_pkg::SUM_BITS-1:0]   quotient;
      s = raw & SAMPLE_MASK;
      // a stored count of zero behaves as one
      limit = (group_limit == '0) ? m3m_pkg::COUNT_BITS'(1) : group_limit;
      case (triple_pos)
         m3m_pkg::PHASE_SECOND: begin
            second_sample = s;
            triple_pos = m3m_pkg::PHASE_THIRD;
         end
         m3m_pkg::PHASE_THIRD: begin
            triple_pos = m3m_pkg::PHASE_FIRST;
            med = median_of(first_sample, second_sample, s);
            running_sum = running_sum + m3m_pkg::SUM_BITS'(med);
            medians_in_group = medians_in_group + 1'b1;
            // a count lowered below the medians already taken closes on this median,
            // divided by what was actually summed
            if (medians_in_group != '0 && medians_in_group >= limit) begin
               quotient = running_sum / medians_in_group;
               expected_averages.push_back(quotient[m3m_pkg::FIELD_BITS-1:0]);
               running_sum = '0;
               medians_in_group = '0;
            end
         end
         default: begin
            // first phase; value three cannot occur and would also start a new triple
            first_sample = s;
            triple_pos = m3m_pkg::PHASE_SECOND;
         end
      endcase
   endfunction

   task report_error(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   // predictor side: every accepted input word
   always @(posedge clock) begin
      if (reset === 1'b0 && req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
         track_sample(req_chan.sample);
   end

   // checker side: every accepted result word against the oldest expectation
   always @(posedge clock) begin
      logic [m3m_pkg::FIELD_BITS-1:0] want;
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_averages.size() == 0) begin
            report_error($sformatf("average %0d with none expected", rsp_chan.average));
         end else begin
            want = expected_averages.pop_front();
            if (rsp_chan.average !== want)
               report_error($sformatf("average got %0d want %0d", rsp_chan.average, want));
         end
      end
   end

   // receiver: a long hold-off when asked, otherwise its own stall pattern
   always @(posedge clock) begin
      rx_tick++;
      if (hold_request != hold_seen) begin
         hold_left = HOLD_CYCLES;
         hold_seen = hold_request;
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else begin
         case (rx_mode)
            RX_ALWAYS:   rsp_chan.ready <= 1'b1;
            RX_RANDOM:   rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_chan.ready <= ((rx_tick % 11) < 4);
            default:     rsp_chan.ready <= 1'b1;
         endcase
      end
   end

   // watchdog: too long with no word moving on either channel ends the run
   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // offer one sample word and hold it until the block takes it;
   // between bursts the sender may drop valid for a random gap
   task send_word(input logic [m3m_pkg::FIELD_BITS-1:0] s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = sender_gaps ? $urandom_range(0, 8) : 0;
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.sample <= s;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
   endtask

   // sender pause until every owed average has come out
   task wait_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_averages.size() != 0);
   endtask

   // a triple that closes no group leaves no trace, so give it time to finish
   task settle_block();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_group_count(input logic [m3m_pkg::COUNT_BITS-1:0] value);
      settle_block();
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      group_limit = value;
   endtask

   // half uniform, the rest rails, repeats and tiny values to force ties
   function logic [m3m_pkg::FIELD_BITS-1:0] pick_sample();
      logic [m3m_pkg::FIELD_BITS-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = '0;
         1:       v = FULL_SCALE;
         2:       v = prev_sample;
         3:       v = m3m_pkg::FIELD_BITS'($urandom_range(0, 15));
         default: v = m3m_pkg::FIELD_BITS'($urandom_range(0, FULL_SCALE));
      endcase
      prev_sample = v;
      return v;
   endfunction

   task send_triple(input logic [m3m_pkg::FIELD_BITS-1:0] a,
                    input logic [m3m_pkg::FIELD_BITS-1:0] b,
                    input logic [m3m_pkg::FIELD_BITS-1:0] c);
      send_word(a);
      send_word(b);
      send_word(c);
   endtask

   // count from reset is one: each triple gives its own median,
   // with the median in each position and the rails on every bit
   task test_median_orders();
      sender_gaps = 1'b1;
      rx_mode = RX_RANDOM;
      send_triple('0, '0, '0);
      send_triple(FULL_SCALE, FULL_SCALE, FULL_SCALE);
      send_triple(12'd2048, 12'd0, FULL_SCALE);
      send_triple(12'd0, 12'd2048, FULL_SCALE);
      send_triple(FULL_SCALE, 12'd0, 12'd2048);
   endtask

   // stored zero averages a single median
   task test_zero_count();
      write_group_count('0);
      send_triple(12'd7, 12'd7, 12'd1);
      send_triple(12'd100, 12'd4000, 12'd2);
   endtask

   // count lowered below the medians already summed, with a triple half done
   task test_lowered_count();
      write_group_count(8'd5);
      send_triple(12'd10, 12'd30, 12'd20);
      send_triple(12'd301, 12'd4, 12'd500);
      send_word(12'd77);
      write_group_count(8'd1);
      send_word(12'd3000);
      send_word(12'd9);
   endtask

   // large group at full scale: enough medians to set the top bit of the running sum
   task test_full_group();
      write_group_count(8'd130);
      rx_mode = RX_RANDOM;
      sender_gaps = 1'b1;
      repeat (130 * 3) send_word(FULL_SCALE);
   endtask

   // receiver holds off while the sender keeps offering, so the block backs up
   task test_output_backpressure();
      write_group_count(8'd1);
      sender_gaps = 1'b0;
      rx_mode = RX_ALWAYS;
      hold_request++;
      repeat (60) send_word(pick_sample());
   endtask

   // sender stops mid-stream until the block has delivered everything
   task test_sender_pause();
      write_group_count(8'd2);
      sender_gaps = 1'b1;
      rx_mode = RX_PERIODIC;
      repeat (12) send_word(pick_sample());
      wait_results();
      repeat (12) send_word(pick_sample());
   endtask

   // random samples across a run of group counts; the large count followed by
   // a small one lowers the count mid-group
   task test_random_groups();
      int n;
      logic [m3m_pkg::COUNT_BITS-1:0] count;
      for (int p = 0; p < 10; p++) begin
         case (p)
            0:       count = 8'd1;
            1:       count = 8'd2;
            2:       count = 8'd0;
            3:       count = 8'd3;
            4:       count = 8'd200;
            5:       count = 8'd4;
            6:       count = 8'd7;
            7:       count = 8'd16;
            default: count = m3m_pkg::COUNT_BITS'($urandom_range(1, 40));
         endcase
         write_group_count(count);
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         sender_gaps = ($urandom_range(0, 3) != 0);
         n = $urandom_range(15, 35);
         for (int i = 0; i < n; i++) begin
            send_word(pick_sample());
            if ($urandom_range(0, 49) == 0)
               wait_results();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.sample = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      group_limit = 8'd1;
      burst_left = 0;
      sender_gaps = 1'b0;
      rx_mode = RX_ALWAYS;
      hold_request = 0;
      prev_sample = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_median_orders();
      test_zero_count();
      test_lowered_count();
      test_full_group();
      test_output_backpressure();
      test_sender_pause();
      test_random_groups();

      settle_block();
      if (expected_averages.size() != 0)
         report_error($sformatf("%0d averages never arrived", expected_averages.size()));
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
